// ===== hdl/csvfs_pkg.sv =====
// Shared types and constants for the CSV field splitter.
package csvfs_pkg;

    localparam logic [7:0] SEMICOLON = 8'h3B;
    localparam logic [7:0] DQUOTE    = 8'h22;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_EOL  = 1'b1;

    localparam logic KIND_CONTENT   = 1'b0;
    localparam logic KIND_FIELD_END = 1'b1;

    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic field_is_empty;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{in_quotes: 1'b0, quote_pending: 1'b0,
                                       field_is_empty: 1'b1};

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [7:0] column;
        logic       line_end;
    } t_result;

endpackage

// ===== hdl/csvfs_step.sv =====
// Per-byte parser step: next quote/column state and the optional result.
module csvfs_step #(
    parameter int COLUMN_BITS = 8
) (
    input  logic                     i_func,
    input  logic [7:0]               i_data_byte,
    input  csvfs_pkg::t_flags        i_flags,
    input  logic [COLUMN_BITS-1:0]   i_column,
    output csvfs_pkg::t_flags        o_flags,
    output logic [COLUMN_BITS-1:0]   o_column,
    output logic                     o_emit,
    output csvfs_pkg::t_result       o_result
);
    import csvfs_pkg::*;

    localparam logic [COLUMN_BITS-1:0] ColumnMax = {COLUMN_BITS{1'b1}};

    logic [COLUMN_BITS+7:0] col_ext;
    logic                   plain;

    assign col_ext = {8'h00, i_column};

    always_comb begin
        o_flags           = i_flags;
        o_column          = i_column;
        o_emit            = 1'b0;
        o_result.kind     = KIND_CONTENT;
        o_result.out_byte = 8'h00;
        o_result.column   = col_ext[7:0];
        o_result.line_end = 1'b0;
        plain             = 1'b0;

        if (i_func == FUNC_EOL) begin
            o_emit            = 1'b1;
            o_result.kind     = KIND_FIELD_END;
            o_result.line_end = 1'b1;
            o_flags           = FLAGS_RESET;
            o_column          = '0;
        end else if (i_flags.quote_pending) begin
            o_flags.quote_pending = 1'b0;
            if (i_data_byte == DQUOTE) begin
                // doubled quote: literal quote, stay quoted
                o_flags.in_quotes      = 1'b1;
                o_flags.field_is_empty = 1'b0;
                o_emit                 = 1'b1;
                o_result.out_byte      = DQUOTE;
            end else begin
                o_flags.in_quotes = 1'b0;
                plain             = 1'b1;
            end
        end else if (i_flags.in_quotes) begin
            if (i_data_byte == DQUOTE) begin
                o_flags.quote_pending = 1'b1;
            end else begin
                o_flags.field_is_empty = 1'b0;
                o_emit                 = 1'b1;
                o_result.out_byte      = i_data_byte;
            end
        end else begin
            plain = 1'b1;
        end

        if (plain) begin
            if (i_data_byte == DQUOTE && i_flags.field_is_empty) begin
                o_flags.in_quotes = 1'b1;
            end else if (i_data_byte == SEMICOLON) begin
                o_emit                 = 1'b1;
                o_result.kind          = KIND_FIELD_END;
                o_flags.field_is_empty = 1'b1;
                if (i_column != ColumnMax) begin
                    o_column = i_column + COLUMN_BITS'(1);
                end
            end else begin
                o_emit                 = 1'b1;
                o_result.out_byte      = i_data_byte;
                o_flags.field_is_empty = 1'b0;
            end
        end
    end

endmodule

// ===== hdl/csv_field_splitter_core.sv =====
// Top level of the CSV field splitter: input register, parser step, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per byte of a
//   semicolon-separated line: i_func = 0 with the byte in i_data_byte, and finally
//   i_func = 1 to mark end of line (byte ignored).
//   Output channel (o_out_valid / i_out_ready) carries zero or one transaction per
//   input: a content byte (o_kind = 0) or a field end (o_kind = 1) with the field
//   index in o_column; o_line_end flags the field end closing the line.
//   Quoted fields: a quote at field start opens quoting, a doubled quote inside
//   quotes is one literal quote, a single quote closes. Column saturates.
//   Path: an accepted input is held in the input register; the parser step
//   works on it and its result is loaded into the result register, from which
//   the output channel takes it.
//   Throughput: one byte per cycle while the output is not stalled; the only loop
//   is the quote/column state update through the parser step logic.
//   Stall: while the result register is full and not taken, the input register
//   holds and o_in_ready drops once it is full too; nothing is lost or repeated.
//   Reset (synchronous, active low) empties both registers and returns the parser
//   to the start of a line, column 0.
module csv_field_splitter_core #(
    parameter int COLUMN_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_column,
    output logic       o_line_end
);
    import csvfs_pkg::*;

    // input register
    logic                   r_in_valid;
    logic                   r_in_func;
    logic [7:0]             r_in_byte;

    // parser state
    t_flags                 r_flags;
    logic [COLUMN_BITS-1:0] r_col;

    // result register
    logic                   r_out_valid;
    t_result                r_out;

    t_flags                 n_flags;
    logic [COLUMN_BITS-1:0] n_col;
    logic                   n_emit;
    t_result                n_out;

    logic                   advance;

    // The input register moves on whenever the result register is free or
    // being emptied this cycle; items without a result just retire.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    csvfs_step #(
        .COLUMN_BITS(COLUMN_BITS)
    ) u_step (
        .i_func      (r_in_func),
        .i_data_byte (r_in_byte),
        .i_flags     (r_flags),
        .i_column    (r_col),
        .o_flags     (n_flags),
        .o_column    (n_col),
        .o_emit      (n_emit),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= FLAGS_RESET;
            r_col       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_flags     <= n_flags;
                r_col       <= n_col;
                r_out_valid <= n_emit;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_func <= i_func;
            r_in_byte <= i_data_byte;
        end
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_out_byte  = r_out.out_byte;
    assign o_column    = r_out.column;
    assign o_line_end  = r_out.line_end;

    // a pending quote only exists inside a quoted section
    a_pending_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.quote_pending |-> r_flags.in_quotes)
        else $error("quote pending outside quotes");

    // end of line returns the parser to the start of a line
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_func == FUNC_EOL) |=>
            (r_col == '0 && r_flags == FLAGS_RESET))
        else $error("state not cleared after end of line");

    // line end is only flagged on a field end, and field ends carry no byte
    a_line_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_end) |-> (o_kind == KIND_FIELD_END))
        else $error("line end on a content byte");

    a_field_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_FIELD_END) |-> (o_out_byte == 8'h00))
        else $error("field end with nonzero byte");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule
